@@ rtl/dtc_pkg.sv @@
// Shared constants and types for the dense-to-CSR threshold compressor.
package dtc_pkg;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned CutoffW   = 63;
  localparam int unsigned IdxW      = 12;
  localparam int unsigned CountW    = 13;
  localparam int unsigned TotalW    = 25;

  localparam logic [IdxW-1:0]   IdxMax   = IdxW'(MaxDim - 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MaxDim);
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [CutoffW-1:0] ExpInf  = 63'h7FF0000000000000;

  localparam logic KindEntry  = 1'b0;
  localparam logic KindRowEnd = 1'b1;

  // One result item.
  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] entry_value;
    logic [IdxW-1:0]   column;
    logic [IdxW-1:0]   row;
    logic [CountW-1:0] row_count;
    logic [TotalW-1:0] row_end_offset;
    logic              overflow;
    logic              matrix_done;
    logic              last;
  } result_t;

endpackage

@@ rtl/dense_to_csr_threshold_compress_core.sv @@
// Top level of the dense-to-CSR threshold compressor.
// Usage: the dense matrix streams in row-major order on the in channel
// (in_valid/in_ready), one binary64 element per item, with row_last and
// matrix_last marking row and matrix ends. Each element whose magnitude
// exceeds cutoff yields an entry item; each row end yields a row-end record
// with the row's kept count and the running row pointer. One input item thus
// gives zero, one or two result items on the out channel (out_valid/out_ready),
// and the last one carries last.
// A result appears in the cycle after its input is accepted. Throughput is
// one input item per cycle while each item makes at most one result and the
// receiver keeps up; when an item makes two results, its record waits in the
// spare slot. The input is held off while a second queued result still
// waits, and also while the output register holds a result that the
// receiver is not taking in that cycle, so a receiver stall reaches in_ready
// in the same cycle. Reset clears all counters and the cutoff, and empties
// the result buffer. The user must write cutoff through cfg_valid/cfg_ready
// only while the block is idle; the block does not enforce this.
module dense_to_csr_threshold_compress_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dtc_pkg::CutoffW-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dtc_pkg::ValueW-1:0]  value,
  input  logic                        row_last,
  input  logic                        matrix_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        kind,
  output logic [dtc_pkg::ValueW-1:0]  entry_value,
  output logic [dtc_pkg::IdxW-1:0]    column,
  output logic [dtc_pkg::IdxW-1:0]    row,
  output logic [dtc_pkg::CountW-1:0]  row_count,
  output logic [dtc_pkg::TotalW-1:0]  row_end_offset,
  output logic                        overflow,
  output logic                        matrix_done,
  output logic                        last
);
  import dtc_pkg::*;

  logic [CutoffW-1:0] cutoff;
  logic [IdxW-1:0]    column_counter;
  logic [IdxW-1:0]    row_counter;
  logic [CountW-1:0]  row_nonzeros;
  logic [TotalW-1:0]  total_nonzeros;
  logic               row_overflowed;

  // Output register (head) and one spare slot behind it.
  result_t head, spare;
  logic    head_valid, spare_valid;

  logic    keep, end_row, accept, pop;
  logic [CountW-1:0] cnt_kept;
  logic [TotalW-1:0] tot_kept;
  result_t ent, rec;

  dtc_compare u_cmp (.value(value), .cutoff(cutoff), .keep(keep));

  assign cfg_ready = 1'b1;
  // Room for two results is guaranteed once the spare slot is empty and the
  // head is either empty or leaving this cycle.
  assign pop      = head_valid && out_ready;
  assign in_ready = !spare_valid && (!head_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign end_row  = row_last || matrix_last;

  assign cnt_kept = (keep && row_nonzeros < CountMax) ? row_nonzeros + 1'b1 : row_nonzeros;
  assign tot_kept = (keep && total_nonzeros < TotalMax) ? total_nonzeros + 1'b1
                                                        : total_nonzeros;

  always_comb begin
    ent = '0;
    ent.kind        = KindEntry;
    ent.entry_value = value;
    ent.column      = column_counter;
    ent.row         = row_counter;
    ent.overflow    = row_overflowed;
    ent.last        = !end_row;
    rec = '0;
    rec.kind           = KindRowEnd;
    rec.row            = row_counter;
    rec.row_count      = cnt_kept;
    rec.row_end_offset = tot_kept;
    rec.overflow       = row_overflowed;
    rec.matrix_done    = matrix_last;
    rec.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= '0;
    end else if (cfg_valid) begin
      cutoff <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      row_nonzeros   <= '0;
      total_nonzeros <= '0;
      row_overflowed <= 1'b0;
    end else if (accept) begin
      if (end_row) begin
        column_counter <= '0;
        row_nonzeros   <= '0;
        row_overflowed <= 1'b0;
        if (matrix_last) begin
          row_counter    <= '0;
          total_nonzeros <= '0;
        end else begin
          total_nonzeros <= tot_kept;
          if (row_counter < IdxMax) begin
            row_counter <= row_counter + 1'b1;
          end
        end
      end else begin
        row_nonzeros   <= cnt_kept;
        total_nonzeros <= tot_kept;
        if (column_counter < IdxMax) begin
          column_counter <= column_counter + 1'b1;
        end else begin
          row_overflowed <= 1'b1;
        end
      end
    end
  end

  // Result buffer: an item's first result lands in head, a second one in spare.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (accept && (keep || end_row)) begin
        // Here spare is empty and head is empty or popping.
        head_valid  <= 1'b1;
        head        <= keep ? ent : rec;
        spare_valid <= keep && end_row;
        spare       <= rec;
      end else if (pop) begin
        head_valid  <= spare_valid;
        head        <= spare;
        spare_valid <= 1'b0;
      end
    end
  end

  assign out_valid      = head_valid;
  assign kind           = head.kind;
  assign entry_value    = head.entry_value;
  assign column         = head.column;
  assign row            = head.row;
  assign row_count      = head.row_count;
  assign row_end_offset = head.row_end_offset;
  assign overflow       = head.overflow;
  assign matrix_done    = head.matrix_done;
  assign last           = head.last;

endmodule

@@ rtl/dtc_compare.sv @@
// Magnitude-above-cutoff test on binary64 bit patterns, NaN never kept.
module dtc_compare (
  input  logic [dtc_pkg::ValueW-1:0]  value,
  input  logic [dtc_pkg::CutoffW-1:0] cutoff,
  output logic                        keep
);
  import dtc_pkg::*;

  logic [CutoffW-1:0] mag;

  assign mag  = value[CutoffW-1:0];
  assign keep = (mag <= ExpInf) && (cutoff <= ExpInf) && (mag > cutoff);

endmodule

@@ rtl/dtc_checker.sv @@
// Port-level checker for the dense-to-CSR threshold compressor, with its bind.
module dtc_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic kind,
  input logic last,
  input logic matrix_done,
  input logic [dtc_pkg::CountW-1:0] row_count,
  input logic [dtc_pkg::ValueW-1:0] entry_value
);
  import dtc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_value) && $stable(kind))
    else $error("result changed while stalled");

  a_rec_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KindRowEnd |-> last)
    else $error("row-end record without last");

  a_done_rec: assert property (@(posedge clk) disable iff (rst)
    out_valid && matrix_done |-> kind == KindRowEnd)
    else $error("matrix_done on an entry");

  a_entry_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KindEntry |-> row_count == '0)
    else $error("entry carries a row count");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind dense_to_csr_threshold_compress_core dtc_checker u_dtc_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last),
  .matrix_done(matrix_done), .row_count(row_count), .entry_value(entry_value)
);
